>>> design/rcfc_pkg.sv
// rcfc_pkg: shared types and constants for the range claim free counter
// no dependencies
package rcfc_pkg;

    localparam int FIELD_W = 13;
    localparam int WORD_W  = 32;
    localparam int OFS_W   = 5;
    localparam int CNT_W   = 6;
    localparam logic [FIELD_W-1:0] N_RESET = 13'd4096;
    localparam int REG_SIZE = 0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_UPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic upd;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic last;
        logic out_busy;
    } t_status;

    function automatic logic [CNT_W-1:0] popcount(input logic [WORD_W-1:0] w);
        logic [CNT_W-1:0] s;
        s = '0;
        for (int i = 0; i < WORD_W; i++) begin
            s = s + CNT_W'(w[i]);
        end
        return s;
    endfunction

endpackage

>>> design/rcfc_if.sv
// rcfc_if: handshake channels for range items and claim results
// depends on rcfc_pkg
interface rcfc_range_if;
    import rcfc_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] range_low;
    logic [FIELD_W-1:0] range_high;
    modport source (output valid, range_low, range_high, input ready);
    modport sink   (input valid, range_low, range_high, output ready);
endinterface

interface rcfc_claim_if;
    import rcfc_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] newly_claimed;
    modport source (output valid, newly_claimed, input ready);
    modport sink   (input valid, newly_claimed, output ready);
endinterface

>>> design/rcfc_ctrl.sv
// rcfc_ctrl: sequencer that walks the claimed range one bitmap word at a time
// depends on rcfc_pkg
module rcfc_ctrl
    import rcfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_READ;
            end
            S_READ: begin
                n_state = i_st.empty ? S_DONE : S_UPD;
            end
            S_UPD: begin
                n_state = i_st.last ? S_DONE : S_READ;
            end
            S_DONE: begin
                if (!i_st.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_READ: o_cmd.rd  = !i_st.empty;
            S_UPD:  o_cmd.upd = 1'b1;
            S_DONE: o_cmd.push = !i_st.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> design/rcfc_dp.sv
// rcfc_dp: free bitmap memory with per-word valid bits, range masks and count
// depends on rcfc_pkg
module rcfc_dp
    import rcfc_pkg::*;
#(
    parameter int MAX_POSITIONS = 4096
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_free_all,
    input  logic [FIELD_W-1:0] i_n,
    input  logic [FIELD_W-1:0] i_low,
    input  logic [FIELD_W-1:0] i_high,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [FIELD_W-1:0] o_out,
    output t_status            o_st
);

    localparam int NW = (MAX_POSITIONS + WORD_W - 1) / WORD_W;
    localparam int AW = (NW > 1) ? $clog2(NW) : 1;

    logic [WORD_W-1:0]  r_mem [NW];
    logic [NW-1:0]      r_vld;
    logic [WORD_W-1:0]  r_rd_data;
    logic               r_rd_vld;
    logic [AW-1:0]      r_addr, r_addr_hi, r_addr_lo;
    logic [OFS_W-1:0]   r_ofs_lo, r_ofs_hi;
    logic               r_empty;
    logic [FIELD_W-1:0] r_acc;
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_out;

    logic [FIELD_W-1:0] lo_c, hi_c, lo0, hi0;
    logic [WORD_W-1:0]  word, mask_lo, mask_hi, mask;

    // clip range to 1..n, indices become zero based
    always_comb begin
        lo_c = (i_low == '0) ? FIELD_W'(1) : i_low;
        hi_c = (i_high > i_n) ? i_n : i_high;
        lo0  = lo_c - FIELD_W'(1);
        hi0  = hi_c - FIELD_W'(1);
    end

    always_comb begin
        word    = r_rd_vld ? r_rd_data : '1;
        mask_lo = (r_addr == r_addr_lo) ? ('1 << r_ofs_lo) : '1;
        mask_hi = (r_addr == r_addr_hi) ? ('1 >> (OFS_W'(WORD_W - 1) - r_ofs_hi)) : '1;
        mask    = mask_lo & mask_hi;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_empty   <= (lo_c > hi_c);
            r_addr_lo <= AW'(lo0 >> OFS_W);
            r_addr_hi <= AW'(hi0 >> OFS_W);
            r_addr    <= AW'(lo0 >> OFS_W);
            r_ofs_lo  <= lo0[OFS_W-1:0];
            r_ofs_hi  <= hi0[OFS_W-1:0];
            r_acc     <= '0;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_addr];
            r_rd_vld  <= r_vld[r_addr];
        end
        if (i_cmd.upd) begin
            r_mem[r_addr] <= word & ~mask;
            r_acc         <= r_acc + FIELD_W'(popcount(word & mask));
            r_addr        <= r_addr + AW'(1);
        end
        if (i_cmd.push) r_out <= r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_free_all) begin
                r_vld <= '0;
            end else if (i_cmd.upd) begin
                r_vld[r_addr] <= 1'b1;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out         = r_out;
    assign o_st.empty    = r_empty;
    assign o_st.last     = (r_addr == r_addr_hi);
    assign o_st.out_busy = r_out_valid && !i_out_ready;

endmodule

>>> design/range_claim_free_counter.sv
// channel   dir  fields                        accepted when
// i_rng     in   range_low, range_high         valid && ready
// o_clm     out  newly_claimed                 valid && ready
// apb       in   positions_in_use at addr 0    psel && penable && pwrite
// a nonempty item is accepted, then each 32-position bitmap word it covers is read
// and written back in turn; an empty item goes from the read state straight to done
// the single-port bitmap memory, one word read then one written, sets this order
// reset and a size write mark every word free through per-word valid bits at once
// a finished count waits in the output register; the next item is taken meanwhile
// depends on rcfc_pkg, rcfc_if, rcfc_ctrl, rcfc_dp
module range_claim_free_counter
    import rcfc_pkg::*;
#(
    parameter int MAX_POSITIONS = 4096
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcfc_range_if.sink  i_rng,
    rcfc_claim_if.source o_clm,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [FIELD_W-1:0] r_n, n_n, wv;
    logic               cfg_wr;
    t_cmd               cmd;
    t_status            st;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'(REG_SIZE));
    assign prdata = (paddr[2] == 1'(REG_SIZE)) ? {{(32-FIELD_W){1'b0}}, r_n} : '0;

    always_comb begin
        wv  = pwdata[FIELD_W-1:0];
        n_n = wv;
        if (wv == '0) n_n = FIELD_W'(1);
        if (32'(wv) > 32'(MAX_POSITIONS)) n_n = FIELD_W'(MAX_POSITIONS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= (32'(N_RESET) > 32'(MAX_POSITIONS)) ? FIELD_W'(MAX_POSITIONS) : N_RESET;
        end else if (cfg_wr) begin
            r_n <= n_n;
        end
    end

    rcfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rng.valid),
        .o_in_ready (i_rng.ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    rcfc_dp #(.MAX_POSITIONS(MAX_POSITIONS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_free_all  (cfg_wr),
        .i_n         (r_n),
        .i_low       (i_rng.range_low),
        .i_high      (i_rng.range_high),
        .i_out_ready (o_clm.ready),
        .o_out_valid (o_clm.valid),
        .o_out       (o_clm.newly_claimed),
        .o_st        (st)
    );

endmodule
